// File: hw/rtl/cfd_pkg.sv
package cfd_pkg;

    // Frame layout constants.
    localparam logic [7:0]  SYNC_FIRST  = 8'hFF;
    localparam logic [7:0]  SYNC_SECOND = 8'hAA;
    localparam logic [15:0] MIN_LENGTH  = 16'd7;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    // Verdict status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SYNC  = 3'd1;
    localparam logic [2:0] ST_SHORT_LEN = 3'd2;
    localparam logic [2:0] ST_TRUNC     = 3'd3;
    localparam logic [2:0] ST_CSUM_BAD  = 3'd4;

    // Result queue geometry.
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [2:0]  status;
        logic [7:0]  seq_number;
        logic [7:0]  frame_kind;
        logic [15:0] frame_length;
        logic        last;
    } result_t;

    // Results caused by one input byte, in delivery order.
    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } step_out_t;

endpackage

// File: hw/rtl/cfd_step.sv
module cfd_step
    import cfd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      take,
    input  logic [7:0] data_byte,
    input  logic      end_of_buffer,
    output step_out_t step
);

    typedef enum logic [3:0] {
        PH_SYNC0   = 4'd0,
        PH_SYNC1   = 4'd1,
        PH_LEN_HI  = 4'd2,
        PH_LEN_LO  = 4'd3,
        PH_SEQ     = 4'd4,
        PH_TYPE    = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CSUM    = 4'd7,
        PH_DONE    = 4'd8
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] seen_reg, seen_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  seq_reg, seq_next;
    logic [7:0]  kind_reg, kind_next;

    logic        clear;
    logic        was_done;
    logic        verdict;
    logic [2:0]  verdict_code;
    logic        trunc;
    logic        payload;
    result_t     pay_res;
    result_t     ver_res;

    always_comb
    begin
        // A new buffer starts from cleared frame state.
        clear     = (phase_reg == PH_SYNC0);
        len_next  = clear ? 16'd0 : len_reg;
        seen_next = clear ? 16'd0 : seen_reg;
        sum_next  = clear ? 8'd0  : sum_reg;
        seq_next  = clear ? 8'd0  : seq_reg;
        kind_next = clear ? 8'd0  : kind_reg;

        was_done = (phase_reg == PH_DONE);
        if (!was_done)
        begin
            seen_next = seen_next + 16'd1;
        end

        phase_next   = phase_reg;
        verdict      = 1'b0;
        verdict_code = ST_OK;
        payload      = 1'b0;

        unique case (phase_reg)
            PH_SYNC0:
            begin
                if (data_byte != SYNC_FIRST)
                begin
                    verdict      = 1'b1;
                    verdict_code = ST_BAD_SYNC;
                end
                else
                begin
                    phase_next = PH_SYNC1;
                end
            end
            PH_SYNC1:
            begin
                if (data_byte != SYNC_SECOND)
                begin
                    verdict      = 1'b1;
                    verdict_code = ST_BAD_SYNC;
                end
                else
                begin
                    phase_next = PH_LEN_HI;
                end
            end
            PH_LEN_HI:
            begin
                len_next   = {data_byte, 8'd0};
                sum_next   = sum_next + data_byte;
                phase_next = PH_LEN_LO;
            end
            PH_LEN_LO:
            begin
                len_next = {len_next[15:8], data_byte};
                sum_next = sum_next + data_byte;
                if ({len_next[15:8], data_byte} < MIN_LENGTH)
                begin
                    verdict      = 1'b1;
                    verdict_code = ST_SHORT_LEN;
                end
                else
                begin
                    phase_next = PH_SEQ;
                end
            end
            PH_SEQ:
            begin
                seq_next   = data_byte;
                sum_next   = sum_next + data_byte;
                phase_next = PH_TYPE;
            end
            PH_TYPE:
            begin
                kind_next  = data_byte;
                sum_next   = sum_next + data_byte;
                phase_next = (len_next == MIN_LENGTH) ? PH_CSUM : PH_PAYLOAD;
            end
            PH_PAYLOAD:
            begin
                sum_next = sum_next + data_byte;
                payload  = 1'b1;
                if (({1'b0, seen_next} + 17'd1) >= {1'b0, len_next})
                begin
                    phase_next = PH_CSUM;
                end
            end
            PH_CSUM:
            begin
                verdict      = 1'b1;
                verdict_code = (~sum_next == data_byte) ? ST_OK : ST_CSUM_BAD;
            end
            default:
            begin
                phase_next = PH_DONE;
                was_done   = 1'b1;
            end
        endcase

        trunc = end_of_buffer && !was_done && !verdict;
        if (verdict)
        begin
            phase_next = PH_DONE;
        end
        if (end_of_buffer)
        begin
            phase_next = PH_SYNC0;
        end

        pay_res              = '0;
        pay_res.result_kind  = KIND_PAYLOAD;
        pay_res.payload_byte = data_byte;
        pay_res.last         = !trunc;

        ver_res              = '0;
        ver_res.result_kind  = KIND_VERDICT;
        ver_res.status       = trunc ? ST_TRUNC : verdict_code;
        ver_res.frame_length = len_next;
        ver_res.last         = 1'b1;
        if (verdict && (verdict_code == ST_OK))
        begin
            ver_res.seq_number = seq_next;
            ver_res.frame_kind = kind_next;
        end

        step.second = ver_res;
        if (payload)
        begin
            step.first = pay_res;
            step.count = trunc ? 2'd2 : 2'd1;
        end
        else
        begin
            step.first = ver_res;
            step.count = (verdict || trunc) ? 2'd1 : 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC0;
            len_reg   <= '0;
            seen_reg  <= '0;
            sum_reg   <= '0;
            seq_reg   <= '0;
            kind_reg  <= '0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            len_reg   <= len_next;
            seen_reg  <= seen_next;
            sum_reg   <= sum_next;
            seq_reg   <= seq_next;
            kind_reg  <= kind_next;
        end
    end

endmodule

// File: hw/rtl/checksummed_frame_deframer_core.sv
// Channel   Direction  Handshake                   Payload
// byte      in         byte_valid / byte_stall     data_byte, end_of_buffer
// result    out        result_valid / result_stall result_kind through last (seven fields)
//
// One byte transaction is taken per cycle while byte_stall is low; its results are written into
// a four-entry result queue at the same edge, and the queue head drives the result port.
// A byte can cause up to two results (a payload byte followed by a truncated verdict),
// so the byte side stalls whenever fewer than two queue entries are free; the queue
// drain of one result per cycle while result_stall is low sets the sustained rate.
// rst_n clears the frame tracker to the first sync byte and empties the queue.
module checksummed_frame_deframer_core
    import cfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_buffer,

    output logic        result_valid,
    input  logic        result_stall,
    output logic        result_kind,
    output logic [7:0]  payload_byte,
    output logic [2:0]  status,
    output logic [7:0]  seq_number,
    output logic [7:0]  frame_kind,
    output logic [15:0] frame_length,
    output logic        last
);

    step_out_t          step;
    logic               take;
    logic               pop;
    logic [1:0]         push_count;

    result_t            queue_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    result_t            head;

    // The byte side is held off while the queue could not absorb a two-result byte.
    assign byte_stall = (count_reg > CNT_W'(FIFO_DEPTH - 2));
    assign take       = byte_valid && !byte_stall;

    // The tracker advances only on an accepted byte transaction.
    cfd_step u_step
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .take          (take),
        .data_byte     (data_byte),
        .end_of_buffer (end_of_buffer),
        .step          (step)
    );

    assign push_count = take ? step.count : 2'd0;

    assign result_valid = (count_reg != '0);
    assign pop          = result_valid && !result_stall;
    assign head         = queue_reg[rd_ptr_reg];

    assign result_kind  = head.result_kind;
    assign payload_byte = head.payload_byte;
    assign status       = head.status;
    assign seq_number   = head.seq_number;
    assign frame_kind   = head.frame_kind;
    assign frame_length = head.frame_length;
    assign last         = head.last;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
        rd_ptr_next = pop ? (rd_ptr_reg + PTR_W'(1)) : rd_ptr_reg;
        count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage carries payload only and needs no reset.
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
        begin
            queue_reg[wr_ptr_reg] <= step.first;
        end
        if (push_count == 2'd2)
        begin
            queue_reg[wr_ptr_reg + PTR_W'(1)] <= step.second;
        end
    end

`ifndef SYNTHESIS
    // The queue never holds more results than it has entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(FIFO_DEPTH))
        else $error("result queue overflow");

    // A byte that causes a result always makes the result port valid next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && (step.count != 2'd0)) |=> result_valid)
        else $error("result lost after accepted byte");

    // Only an ok verdict carries the captured sequence and type bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result_kind == KIND_VERDICT) && (status != ST_OK))
            |-> ((seq_number == 8'd0) && (frame_kind == 8'd0)))
        else $error("failed verdict carries header fields");

    // A payload result that is not last is followed by a truncated verdict.
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && (step.count == 2'd2))
            |-> ((step.first.result_kind == KIND_PAYLOAD) && !step.first.last
                 && (step.second.status == ST_TRUNC)))
        else $error("bad two-result ordering");
`endif

endmodule
